@@ src/ordered_unique_key_set_top_assert.svh @@
// Assertion macros used by the checker of this block.
`ifndef ORDERED_UNIQUE_KEY_SET_TOP_ASSERT_SVH
`define ORDERED_UNIQUE_KEY_SET_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OUKS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ordered_unique_key_set assertion failed");

// Next-cycle implication, checked outside reset.
`define OUKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ordered_unique_key_set assertion failed");

`endif

@@ src/ouks_pkg.sv @@
package ouks_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_PRESENT   = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam int unsigned CountOutBits = 5;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ src/ordered_unique_key_set_top.sv @@
// Ordered set of unique keys held in a row of ENTRIES cells. An item is taken
// while the block is idle; at that edge every cell compares its key with the
// incoming one, and the match is registered. Then, in the update state, the
// set is updated (append at the end, or removal with every later key moving
// down one cell) and the result is written to the output register. The update
// waits while a previous result has not been taken, and no new item is taken
// until the update is done.
module ordered_unique_key_set_top import ouks_pkg::*; #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [KEY_BITS-1:0] key_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [4:0]          key_count_o
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic                state_q, state_d;
  logic                cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [2:0]          status_q, status_d;
  logic [4:0]          out_cnt_q;
  logic [4:0]          out_cnt_d;
  logic [CntW+4:0]     cnt_ext;

  logic                in_fire;
  logic                upd_go;
  logic                found;
  logic [IdxW-1:0]     pos;
  logic [ENTRIES-1:0]  hit;
  logic [ENTRIES-1:0]  occ;
  logic [KEY_BITS-1:0] cell_key [ENTRIES];
  cell_ctrl_t          ctrl [ENTRIES];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign upd_go     = (state_q == S_UPD) && (!out_valid_q || out_ready_i);

  always_comb begin
    pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit[i]) begin
        pos = pos | IdxW'(i);
      end
    end
  end
  assign found = |hit;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic [KEY_BITS-1:0] nbr_key;

    if (g == ENTRIES - 1) begin : g_last
      assign nbr_key = cell_key[g];
    end else begin : g_mid
      assign nbr_key = cell_key[g+1];
    end

    assign occ[g] = CntW'(g) < cnt_q;
    assign ctrl[g].load  = upd_go && (cmd_q == CMD_INSERT) && !found &&
                           (cnt_q == CntW'(g));
    assign ctrl[g].shift = upd_go && (cmd_q == CMD_REMOVE) && found &&
                           (IdxW'(g) >= pos);

    ouks_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cap_en_i (in_fire),
      .occ_i    (occ[g]),
      .cmp_key_i(key_i),
      .new_key_i(key_q),
      .nbr_key_i(nbr_key),
      .ctrl_i   (ctrl[g]),
      .key_o    (cell_key[g]),
      .hit_o    (hit[g])
    );
  end

  always_comb begin
    cnt_d       = cnt_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    state_d     = state_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_go) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          if (cmd_q == CMD_INSERT) begin
            if (found) begin
              status_d = ST_PRESENT;
            end else if (cnt_q == CntW'(ENTRIES)) begin
              status_d = ST_FULL;
            end else begin
              status_d = ST_INSERTED;
              cnt_d    = cnt_q + CntW'(1);
            end
          end else begin
            if (found) begin
              status_d = ST_REMOVED;
              cnt_d    = cnt_q - CntW'(1);
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    cnt_ext   = {5'd0, cnt_d};
    out_cnt_d = cnt_ext[CountOutBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_i;
      key_q <= key_i;
    end
    if (upd_go) begin
      status_q  <= status_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign key_count_o = out_cnt_q;

endmodule

@@ src/ouks_cell.sv @@
module ouks_cell import ouks_pkg::*; #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cap_en_i,
  input  logic                occ_i,
  input  logic [KEY_BITS-1:0] cmp_key_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [KEY_BITS-1:0] nbr_key_i,
  input  cell_ctrl_t          ctrl_i,
  output logic [KEY_BITS-1:0] key_o,
  output logic                hit_o
);

  logic [KEY_BITS-1:0] key_q;
  logic                hit_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q <= new_key_i;
    end else if (ctrl_i.shift) begin
      key_q <= nbr_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cap_en_i) begin
      hit_q <= occ_i && (key_q == cmp_key_i);
    end
  end

  assign key_o = key_q;
  assign hit_o = hit_q;

endmodule

@@ src/ouks_checker.sv @@
`include "ordered_unique_key_set_top_assert.svh"

module ouks_checker import ouks_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o,
  input logic [4:0] key_count_o
);

  localparam int unsigned EntW = $clog2(ENTRIES + 1) + 5;
  localparam logic [EntW-1:0] EntriesExt = EntW'(ENTRIES);

  logic [4:0] cnt_q;

  // Count of the last delivered item, zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      cnt_q <= key_count_o;
    end
  end

  `OUKS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(key_count_o))
  `OUKS_ASSERT_IMPL(a_full_count, clk_i, rst_ni, out_valid_o && (status_o == ST_FULL), key_count_o == EntriesExt[4:0])
  `OUKS_ASSERT_IMPL(a_removed_count, clk_i, rst_ni, out_valid_o && (status_o == ST_REMOVED), key_count_o == cnt_q - 5'd1)
  `OUKS_ASSERT_IMPL(a_kept_count, clk_i, rst_ni, out_valid_o && ((status_o == ST_PRESENT) || (status_o == ST_NOT_FOUND) || (status_o == ST_FULL)), key_count_o == cnt_q)

endmodule

bind ordered_unique_key_set_top ouks_checker #(
  .ENTRIES(ENTRIES)
) u_ouks_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .status_o   (status_o),
  .key_count_o(key_count_o)
);

@@ tb/tb_ordered_unique_key_set_top.sv @@
`timescale 1ns / 100ps

module tb_ordered_unique_key_set_top;
  import ouks_pkg::*;

  localparam int unsigned SetDepth    = 16;
  localparam int unsigned KeyBits     = 32;
  localparam int unsigned RandomItems = 1025;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned LongHold    = 300;

  typedef struct {
    logic                op;
    logic [KeyBits-1:0]  key;
    bit                  drain_first;
  } set_command_t;

  typedef struct {
    logic [2:0] status;
    logic [4:0] count;
  } set_outcome_t;

  logic               clk = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = CMD_INSERT;
  logic [KeyBits-1:0] key = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         status;
  logic [4:0]         key_count;

  logic [KeyBits-1:0] set_keys [SetDepth];
  int unsigned        set_size = 0;

  set_command_t queued_commands [$];
  set_outcome_t pending_outcomes [$];
  set_command_t next_command;
  set_outcome_t oldest_outcome;

  logic        in_fire = 1'b0;
  int unsigned send_gap = 0;
  int unsigned rx_stall = 0;
  bit          long_hold_done = 1'b0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned total_items = 0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned status_seen [8];

  ordered_unique_key_set_top #(
    .ENTRIES (SetDepth),
    .KEY_BITS(KeyBits)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .cmd_i      (cmd),
    .key_i      (key),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .status_o   (status),
    .key_count_o(key_count)
  );

  always #6 clk = ~clk;

  function automatic set_outcome_t key_set_apply(logic op, logic [KeyBits-1:0] k);
    set_outcome_t res;
    int           pos;
    int           i;
    pos = -1;
    for (i = 0; i < int'(set_size); i++) begin
      if (pos < 0 && set_keys[i] == k) begin
        pos = i;
      end
    end
    if (op == CMD_INSERT) begin
      if (pos >= 0) begin
        res.status = ST_PRESENT;
      end else if (set_size >= SetDepth) begin
        res.status = ST_FULL;
      end else begin
        set_keys[set_size] = k;
        set_size++;
        res.status = ST_INSERTED;
      end
    end else begin
      if (pos < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        for (i = pos; i + 1 < int'(set_size); i++) begin
          set_keys[i] = set_keys[i+1];
        end
        set_size--;
        res.status = ST_REMOVED;
      end
    end
    res.count = 5'(set_size);
    return res;
  endfunction

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 92) begin
      return $urandom_range(4, 8);
    end
    return $urandom_range(20, 40);
  endfunction

  task automatic add_command(logic op, logic [KeyBits-1:0] k, bit drain_first);
    set_command_t c;
    c.op = op;
    c.key = k;
    c.drain_first = drain_first;
    queued_commands = {queued_commands, c};
  endtask

  // Results are checked before the accepted item is predicted, since a result
  // can never belong to an item taken at the same edge.
  always @(posedge clk) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        status_seen[status]++;
        if (pending_outcomes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, status %0d count %0d", $time, status, key_count);
        end else begin
          oldest_outcome = pending_outcomes.pop_front();
          if (status !== oldest_outcome.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d actual %0d", $time,
                     oldest_outcome.status, status);
          end
          if (key_count !== oldest_outcome.count) begin
            errors++;
            $display("%0t: key_count mismatch, expected %0d actual %0d", $time,
                     oldest_outcome.count, key_count);
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_outcomes = {pending_outcomes, key_set_apply(cmd, key)};
        items_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d of %0d items taken", $time, items_taken, total_items);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // An item marked drain_first is held back until every result has come.
  always @(negedge clk) begin
    if (rst_ni && (!in_valid || in_fire)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (queued_commands.size() > 0 &&
                   !(queued_commands[0].drain_first && pending_outcomes.size() > 0)) begin
        next_command = queued_commands.pop_front();
        in_valid <= 1'b1;
        cmd <= next_command.op;
        key <= next_command.key;
        if ((items_taken / 128) % 4 == 2 || $urandom_range(0, 99) < 55) begin
          send_gap <= 0;
        end else begin
          send_gap <= idle_length();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 400) begin
      long_hold_done <= 1'b1;
      rx_stall <= LongHold;
      out_ready <= 1'b0;
    end else if ((results_seen / 128) % 4 != 1 && $urandom_range(0, 99) < 25) begin
      rx_stall <= idle_length() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    logic [KeyBits-1:0] key_pool [24];
    int unsigned        pool_size;
    int unsigned        insert_pct;
    logic [KeyBits-1:0] k;
    logic               op;
    int unsigned        n;
    int unsigned        j;

    pool_size = 4;
    insert_pct = 50;
    add_command(CMD_REMOVE, 32'h0000_0005, 1'b0);
    add_command(CMD_INSERT, 32'h8000_0000, 1'b0);
    add_command(CMD_INSERT, 32'h7FFF_FFFF, 1'b0);
    add_command(CMD_INSERT, 32'h0000_0000, 1'b0);
    add_command(CMD_INSERT, 32'hFFFF_FFFF, 1'b0);
    add_command(CMD_INSERT, 32'h8000_0000, 1'b0);
    add_command(CMD_REMOVE, 32'h0000_0000, 1'b0);
    for (j = 0; j < 13; j++) begin
      add_command(CMD_INSERT, 32'h1 << j, 1'b0);
    end
    add_command(CMD_INSERT, 32'hDEAD_BEEF, 1'b0);
    add_command(CMD_INSERT, 32'h7FFF_FFFF, 1'b0);
    add_command(CMD_REMOVE, 32'h8000_0000, 1'b0);
    add_command(CMD_REMOVE, 32'h0000_1000, 1'b0);
    add_command(CMD_INSERT, 32'hDEAD_BEEF, 1'b0);

    // Keys come mostly from a small pool so that hits, removals and a full set
    // are frequent; the insert share changes per phase to sweep the fill level.
    for (n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) begin
        pool_size = $urandom_range(4, 24);
        for (j = 0; j < pool_size; j++) begin
          key_pool[j] = $urandom;
        end
        if ($urandom_range(0, 1) == 1) begin
          key_pool[0] = 32'h8000_0000;
          key_pool[1] = 32'h7FFF_FFFF;
        end
        case ($urandom_range(0, 3))
          0: insert_pct = 30;
          1: insert_pct = 50;
          2: insert_pct = 75;
          default: insert_pct = 95;
        endcase
      end
      if ($urandom_range(0, 99) < 5) begin
        k = $urandom;
      end else begin
        k = key_pool[$urandom_range(0, pool_size - 1)];
      end
      op = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
      add_command(op, k, n % 300 == 0);
    end
    total_items = queued_commands.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    while (items_taken < total_items) @(posedge clk);
    while (pending_outcomes.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d items: %0d inserted, %0d present, %0d removed, %0d not found, %0d full.",
             items_taken, status_seen[ST_INSERTED], status_seen[ST_PRESENT],
             status_seen[ST_REMOVED], status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
    $display("Random gaps on both sides, one long output stall and drain pauses; %0d errors.",
             errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/ouks_pkg.sv
src/ouks_cell.sv
src/ordered_unique_key_set_top.sv
src/ouks_checker.sv
tb/tb_ordered_unique_key_set_top.sv
